// File: src/drpi_pkg.sv
// Shared constants, types and the arctangent table for the pose integrator.
`timescale 1ns / 1ps

package drpi_pkg;

    // Field widths of the item and result channels.
    localparam int VAL_W = 32;
    localparam int ANG_W = 16;
    localparam int CNT_W = 8;

    // Defaults for the top-level parameters.
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int POS_WIDTH_DEF    = 32;

    // Arctangent table length and the index width it needs.
    localparam int ATAN_LEN = 24;
    localparam int ITER_W   = $clog2(ATAN_LEN);

    // Datapath widths: full product, CORDIC vector (Q16.24 plus growth) and angle.
    localparam int MUL_W     = 64;
    localparam int DATA_W    = 44;
    localparam int Z_W       = 34;
    localparam int RND_SHIFT = 22;
    localparam int OUT_SHIFT = 8;

    // CORDIC limit gain 0.60725293 in Q30.
    localparam logic signed [VAL_W-1:0] GAIN_Q30 = 32'sd652032874;

    // Report interval after reset.
    localparam logic [CNT_W-1:0] REPORT_INTERVAL_RST = 8'd1;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic              load;
        logic              pose_load;
        logic              mul_x;
        logic              mul_y;
        logic              load_y;
        logic              step;
        logic              finish;
        logic              emit;
        logic [ITER_W-1:0] iter;
    } drpi_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic report;
    } drpi_sts_t;

    // atan(2^-i) in units of 2^-32 turn.
    function automatic logic signed [Z_W-1:0] atan_turn(input logic [ITER_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 34'sh020000000;
            5'd1:    v = 34'sh012E4051E;
            5'd2:    v = 34'sh009FB385B;
            5'd3:    v = 34'sh0051111D4;
            5'd4:    v = 34'sh0028B0D43;
            5'd5:    v = 34'sh00145D7E1;
            5'd6:    v = 34'sh000A2F61E;
            5'd7:    v = 34'sh000517C55;
            5'd8:    v = 34'sh00028BE53;
            5'd9:    v = 34'sh000145F2F;
            5'd10:   v = 34'sh0000A2F98;
            5'd11:   v = 34'sh0000517CC;
            5'd12:   v = 34'sh000028BE6;
            5'd13:   v = 34'sh0000145F3;
            5'd14:   v = 34'sh00000A2FA;
            5'd15:   v = 34'sh00000517D;
            5'd16:   v = 34'sh0000028BE;
            5'd17:   v = 34'sh00000145F;
            5'd18:   v = 34'sh000000A30;
            5'd19:   v = 34'sh000000518;
            5'd20:   v = 34'sh00000028C;
            5'd21:   v = 34'sh000000146;
            5'd22:   v = 34'sh0000000A3;
            5'd23:   v = 34'sh000000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: src/drpi_in_if.sv
// Channel interface for incoming motion and set-pose items.
`timescale 1ns / 1ps

interface drpi_in_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic signed [drpi_pkg::VAL_W-1:0]   value_x;
    logic signed [drpi_pkg::VAL_W-1:0]   value_y;
    logic signed [drpi_pkg::ANG_W-1:0]   value_theta;

    modport source (output valid, cmd, value_x, value_y, value_theta, input ready);
    modport sink   (input valid, cmd, value_x, value_y, value_theta, output ready);
endinterface

// File: src/drpi_out_if.sv
// Channel interface for outgoing pose report items.
`timescale 1ns / 1ps

interface drpi_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [drpi_pkg::VAL_W-1:0]   rot_dx;
    logic signed [drpi_pkg::VAL_W-1:0]   rot_dy;
    logic signed [drpi_pkg::ANG_W-1:0]   delta_heading;
    logic signed [drpi_pkg::VAL_W-1:0]   pose_x;
    logic signed [drpi_pkg::VAL_W-1:0]   pose_y;
    logic signed [drpi_pkg::ANG_W-1:0]   pose_heading;

    modport source (output valid, rot_dx, rot_dy, delta_heading, pose_x, pose_y,
                    pose_heading, input ready);
    modport sink   (input valid, rot_dx, rot_dy, delta_heading, pose_x, pose_y,
                    pose_heading, output ready);
endinterface

// File: src/drpi_datapath.sv
// Datapath: gain multiplier, iterative CORDIC rotator, pose accumulators and report counter.
`timescale 1ns / 1ps

module drpi_datapath #(
    parameter int POS_WIDTH = drpi_pkg::POS_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  drpi_pkg::drpi_cmd_t                 cmd,
    output drpi_pkg::drpi_sts_t                 sts,
    input  logic                                cfg_we,
    input  logic [drpi_pkg::CNT_W-1:0]          cfg_wdata,
    input  logic signed [drpi_pkg::VAL_W-1:0]   value_x,
    input  logic signed [drpi_pkg::VAL_W-1:0]   value_y,
    input  logic signed [drpi_pkg::ANG_W-1:0]   value_theta,
    output logic signed [drpi_pkg::VAL_W-1:0]   rot_dx,
    output logic signed [drpi_pkg::VAL_W-1:0]   rot_dy,
    output logic signed [drpi_pkg::ANG_W-1:0]   delta_heading,
    output logic signed [drpi_pkg::VAL_W-1:0]   pose_x,
    output logic signed [drpi_pkg::VAL_W-1:0]   pose_y,
    output logic signed [drpi_pkg::ANG_W-1:0]   pose_heading
);

    localparam int VAL_W  = drpi_pkg::VAL_W;
    localparam int ANG_W  = drpi_pkg::ANG_W;
    localparam int CNT_W  = drpi_pkg::CNT_W;
    localparam int MUL_W  = drpi_pkg::MUL_W;
    localparam int DATA_W = drpi_pkg::DATA_W;
    localparam int Z_W    = drpi_pkg::Z_W;
    localparam int EXT_W  = 64;

    localparam logic signed [ANG_W-1:0]  QUARTER_POS = 16'sd16384;
    localparam logic signed [ANG_W-1:0]  QUARTER_NEG = -16'sd16384;
    localparam logic [ANG_W-1:0]         HALF_TURN   = 16'h8000;
    localparam logic signed [MUL_W-1:0]  RND_HALF    = MUL_W'(1) <<< (drpi_pkg::RND_SHIFT - 1);
    localparam logic signed [DATA_W-1:0] OUT_HALF    = DATA_W'(1) <<< (drpi_pkg::OUT_SHIFT - 1);
    localparam logic signed [DATA_W-1:0] SAT_HI      = (DATA_W'(1) <<< (VAL_W - 1)) - DATA_W'(1);
    localparam logic signed [DATA_W-1:0] SAT_LO      = -(DATA_W'(1) <<< (VAL_W - 1));

    // Latched item and rotation set-up.
    logic signed [VAL_W-1:0]  vx_reg, vy_reg;
    logic signed [ANG_W-1:0]  vt_reg;
    logic signed [ANG_W-1:0]  ang_reg;
    logic                     flip_reg;

    // Multiplier and CORDIC registers.
    logic signed [MUL_W-1:0]  prod_reg;
    logic signed [DATA_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic signed [VAL_W-1:0]  rx_reg, ry_reg;

    // Architectural state.
    logic signed [POS_WIDTH-1:0] acc_x_reg, acc_y_reg;
    logic signed [ANG_W-1:0]     acc_heading_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            interval_reg;

    // Output payload registers.
    logic signed [VAL_W-1:0] out_rx_reg, out_ry_reg, out_px_reg, out_py_reg;
    logic signed [ANG_W-1:0] out_dh_reg, out_ph_reg;

    logic signed [ANG_W-1:0]  ang_raw;
    logic                     flip_next;
    logic signed [ANG_W-1:0]  ang_next;
    logic signed [VAL_W:0]    mul_src;
    logic signed [VAL_W:0]    mul_op;
    logic signed [MUL_W-1:0]  prod_full;
    logic signed [MUL_W-1:0]  prod_rnd;
    logic signed [DATA_W-1:0] scaled;
    logic signed [DATA_W-1:0] sh_x, sh_y;
    logic signed [Z_W-1:0]    atan_val;
    logic signed [DATA_W-1:0] fx_full, fy_full;
    logic signed [VAL_W-1:0]  rx_next, ry_next;
    logic [CNT_W-1:0]         count_inc;
    logic signed [EXT_W-1:0]  px_ext, py_ext;

    // Angle to rotate by is minus the heading, folded into a half turn.
    assign ang_raw   = -acc_heading_reg;
    assign flip_next = (ang_raw > QUARTER_POS) || (ang_raw < QUARTER_NEG);
    assign ang_next  = flip_next ? (ang_raw ^ HALF_TURN) : ang_raw;

    // Gain multiply on the (possibly negated) operand, then round half up to Q16.24.
    assign mul_src   = cmd.mul_y ? (VAL_W + 1)'(vy_reg) : (VAL_W + 1)'(vx_reg);
    assign mul_op    = flip_reg ? -mul_src : mul_src;
    assign prod_full = MUL_W'(mul_op) * MUL_W'(drpi_pkg::GAIN_Q30);
    assign prod_rnd  = (prod_reg + RND_HALF) >>> drpi_pkg::RND_SHIFT;
    assign scaled    = prod_rnd[DATA_W-1:0];

    // One CORDIC micro-rotation per step.
    assign sh_x     = x_reg >>> cmd.iter;
    assign sh_y     = y_reg >>> cmd.iter;
    assign atan_val = drpi_pkg::atan_turn(cmd.iter);

    // Round to Q16.16 and saturate.
    assign fx_full = (x_reg + OUT_HALF) >>> drpi_pkg::OUT_SHIFT;
    assign fy_full = (y_reg + OUT_HALF) >>> drpi_pkg::OUT_SHIFT;

    always_comb
    begin
        if (fx_full > SAT_HI)
            rx_next = VAL_W'(SAT_HI);
        else if (fx_full < SAT_LO)
            rx_next = VAL_W'(SAT_LO);
        else
            rx_next = fx_full[VAL_W-1:0];
        if (fy_full > SAT_HI)
            ry_next = VAL_W'(SAT_HI);
        else if (fy_full < SAT_LO)
            ry_next = VAL_W'(SAT_LO);
        else
            ry_next = fy_full[VAL_W-1:0];
    end

    // Report decision on the incremented count.
    assign count_inc  = count_reg + CNT_W'(1);
    assign sts.report = (count_inc == interval_reg);

    // Pose outputs carry the sign-extended accumulator.
    assign px_ext = EXT_W'(acc_x_reg);
    assign py_ext = EXT_W'(acc_y_reg);

    // Item latch, multiplier and CORDIC iteration registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vx_reg   <= value_x;
            vy_reg   <= value_y;
            vt_reg   <= value_theta;
            ang_reg  <= ang_next;
            flip_reg <= flip_next;
        end
        if (cmd.mul_x || cmd.mul_y)
            prod_reg <= prod_full;
        if (cmd.mul_y)
            x_reg <= scaled;
        if (cmd.load_y)
        begin
            y_reg <= scaled;
            z_reg <= $signed({{(Z_W - ANG_W - 16){ang_reg[ANG_W-1]}}, ang_reg, 16'b0});
        end
        if (cmd.step)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_reg <= x_reg - sh_y;
                y_reg <= y_reg + sh_x;
                z_reg <= z_reg - atan_val;
            end
            else
            begin
                x_reg <= x_reg + sh_y;
                y_reg <= y_reg - sh_x;
                z_reg <= z_reg + atan_val;
            end
        end
        if (cmd.finish)
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
        end
    end

    // Pose, heading, counter and report interval.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
            acc_heading_reg <= '0;
            count_reg       <= '0;
            interval_reg    <= drpi_pkg::REPORT_INTERVAL_RST;
        end
        else
        begin
            if (cfg_we)
                interval_reg <= cfg_wdata;
            if (cmd.pose_load)
            begin
                acc_x_reg       <= POS_WIDTH'(value_x);
                acc_y_reg       <= POS_WIDTH'(value_y);
                acc_heading_reg <= value_theta;
            end
            else if (cmd.finish)
            begin
                acc_x_reg       <= acc_x_reg + POS_WIDTH'(rx_next);
                acc_y_reg       <= acc_y_reg + POS_WIDTH'(ry_next);
                acc_heading_reg <= acc_heading_reg + vt_reg;
                count_reg       <= sts.report ? '0 : count_inc;
            end
        end
    end

    // Result register, loaded when the report item is issued.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_rx_reg <= rx_reg;
            out_ry_reg <= ry_reg;
            out_dh_reg <= vt_reg;
            out_px_reg <= px_ext[VAL_W-1:0];
            out_py_reg <= py_ext[VAL_W-1:0];
            out_ph_reg <= acc_heading_reg;
        end
    end

    assign rot_dx        = out_rx_reg;
    assign rot_dy        = out_ry_reg;
    assign delta_heading = out_dh_reg;
    assign pose_x        = out_px_reg;
    assign pose_y        = out_py_reg;
    assign pose_heading  = out_ph_reg;

endmodule

// File: src/drpi_controller.sv
// Sequencer: accepts items, steps the CORDIC iterations and issues report items.
`timescale 1ns / 1ps

module drpi_controller #(
    parameter int CORDIC_STEPS = drpi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_cmd,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output drpi_pkg::drpi_cmd_t cmd,
    input  drpi_pkg::drpi_sts_t sts
);

    localparam int ITW = $clog2(CORDIC_STEPS);
    localparam int IW  = drpi_pkg::ITER_W;
    localparam logic [ITW-1:0] ITER_LAST = ITW'(CORDIC_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULX,
        S_MULY,
        S_LOADY,
        S_ITER,
        S_FINISH,
        S_EMIT
    } state_t;

    state_t         state_reg, state_next;
    logic [ITW-1:0] iter_reg, iter_next;
    logic           out_valid_reg, out_valid_next;
    logic           accept;
    logic           out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Command decode and next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.iter       = IW'(iter_reg);
        case (state_reg)
            S_IDLE:
            begin
                cmd.load      = accept;
                cmd.pose_load = accept && in_cmd;
                if (accept && !in_cmd)
                    state_next = S_MULX;
            end
            S_MULX:
            begin
                cmd.mul_x  = 1'b1;
                state_next = S_MULY;
            end
            S_MULY:
            begin
                cmd.mul_y  = 1'b1;
                state_next = S_LOADY;
            end
            S_LOADY:
            begin
                cmd.load_y = 1'b1;
                iter_next  = '0;
                state_next = S_ITER;
            end
            S_ITER:
            begin
                cmd.step  = 1'b1;
                iter_next = iter_reg + ITW'(1);
                if (iter_reg == ITER_LAST)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = sts.report ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A motion item occupies the sequencer for the following cycle.
    a_motion_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_cmd) |=> !in_ready)
        else $error("sequencer ready straight after a motion item");

    // A report item is only loaded when the result register is free.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result register overwritten while still held");

    // The iteration index stays within the configured step count.
    a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ITER) |-> (int'(iter_reg) < CORDIC_STEPS))
        else $error("CORDIC iteration index out of range");

    // After the final step the sequencer either returns to idle or issues a report.
    a_finish_next: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (in_ready || (state_reg == S_EMIT)))
        else $error("unexpected state after finishing an item");

    // The result valid rises only through an issued report.
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.emit))
        else $error("result valid raised without a report");

endmodule

// File: src/dead_reckoning_pose_integrator.sv
// Top level of the dead-reckoning pose integrator: sequencer plus datapath.
// A motion item keeps the input from taking another item until it is finished, set by the
// iterative CORDIC rotator: two multiply steps, a load, one micro-rotation per cycle and a
// finishing step; a reporting item adds an issue step, and its report valid rises once that
// step loads the result register: at once if the register is free, later if not.
// A set-pose item completes in its acceptance cycle, so the next item can follow at once.
// Reset (rst_n, asynchronous, active low) clears pose, heading and counter, sets the report
// interval to one and empties the result register; no clearing pass is needed.
`timescale 1ns / 1ps

module dead_reckoning_pose_integrator #(
    parameter int CORDIC_STEPS = drpi_pkg::CORDIC_STEPS_DEF,
    parameter int POS_WIDTH    = drpi_pkg::POS_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [drpi_pkg::CNT_W-1:0]  cfg_wdata,
    drpi_in_if.sink                     motion,
    drpi_out_if.source                  report
);

    drpi_pkg::drpi_cmd_t cmd;
    drpi_pkg::drpi_sts_t sts;

    // Sequencer.
    drpi_controller #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (motion.valid),
        .in_cmd    (motion.cmd),
        .in_ready  (motion.ready),
        .out_valid (report.valid),
        .out_ready (report.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Arithmetic and state.
    drpi_datapath #(
        .POS_WIDTH (POS_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .value_x       (motion.value_x),
        .value_y       (motion.value_y),
        .value_theta   (motion.value_theta),
        .rot_dx        (report.rot_dx),
        .rot_dy        (report.rot_dy),
        .delta_heading (report.delta_heading),
        .pose_x        (report.pose_x),
        .pose_y        (report.pose_y),
        .pose_heading  (report.pose_heading)
    );

endmodule
